>>> rtl/hms_pkg.sv
// ----------------------------------------------------------------------------
// hms_pkg
// shared constants, types and control structs of the histogram merge block
// ----------------------------------------------------------------------------
package hms_pkg;

    localparam int HMS_NUM_CHARS  = 256;
    localparam int HMS_IDX_W      = $clog2(HMS_NUM_CHARS);
    localparam int HMS_COUNT_BITS = 32;
    localparam int HMS_MERGE_W    = 32;
    localparam int HMS_OUT_W      = 32;
    localparam int HMS_FIELD_IDX_W = 8;
    localparam int HMS_DIV_STEPS  = HMS_COUNT_BITS;
    localparam int HMS_STEP_W     = $clog2(HMS_DIV_STEPS);

    typedef enum logic [1:0] {
        MODE_SUM = 2'd0,
        MODE_MAX = 2'd1,
        MODE_MIN = 2'd2,
        MODE_AVG = 2'd3
    } t_stat_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_FIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic update;
        logic div_step;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic avg_mode;
        logic div_last;
        logic out_busy;
    } t_status;

endpackage

>>> rtl/hms_ctrl.sv
// ----------------------------------------------------------------------------
// hms_ctrl
// sequencer: capture, update, divide (average mode only), hand off to output register
// ----------------------------------------------------------------------------
module hms_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  hms_pkg::t_status i_status,
    output hms_pkg::t_cmd   o_cmd
);
    import hms_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                n_state = i_status.avg_mode ? ST_DIV : ST_FIN;
            end
            ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!i_status.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall     = 1'b0;
                o_cmd.load_in  = i_in_valid;
            end
            ST_CALC: o_cmd.update   = 1'b1;
            ST_DIV:  o_cmd.div_step = 1'b1;
            ST_FIN:  o_cmd.load_out = !i_status.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> rtl/hms_dpath.sv
// ----------------------------------------------------------------------------
// hms_dpath
// per-character store, merge arithmetic, serial divider and output register
// ----------------------------------------------------------------------------
module hms_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  hms_pkg::t_cmd                        i_cmd,
    output hms_pkg::t_status                     o_status,
    input  logic                                 i_cfg_write,
    input  logic [1:0]                           i_cfg_stat_mode,
    input  logic [hms_pkg::HMS_FIELD_IDX_W-1:0]  i_char_index,
    input  logic [hms_pkg::HMS_OUT_W-1:0]        i_occurrence_count,
    input  logic                                 i_last_of_array,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic [hms_pkg::HMS_FIELD_IDX_W-1:0]  o_result_index,
    output logic [hms_pkg::HMS_OUT_W-1:0]        o_stat_value,
    output logic                                 o_saturated
);
    import hms_pkg::*;

    localparam int CW = HMS_COUNT_BITS;

    t_stat_mode               r_mode;
    logic [CW-1:0]            r_mem [HMS_NUM_CHARS];
    logic [HMS_NUM_CHARS-1:0] r_vld;
    logic [CW-1:0]            r_rd;
    logic                     r_rd_vld;
    logic [HMS_IDX_W-1:0]     r_idx;
    logic [CW-1:0]            r_cnt;
    logic                     r_last;
    logic [CW-1:0]            r_nv;
    logic                     r_sat;
    logic                     r_is_avg;
    logic [HMS_MERGE_W-1:0]   r_merged;
    logic [HMS_MERGE_W:0]     r_den;
    logic [CW-1:0]            r_quo;
    logic [CW:0]              r_rem;
    logic [HMS_STEP_W-1:0]    r_step;
    logic                     r_out_valid;
    logic [HMS_FIELD_IDX_W-1:0] r_out_idx;
    logic [HMS_OUT_W-1:0]     r_out_val;
    logic                     r_out_sat;

    logic [HMS_IDX_W-1:0]     w_in_idx;
    logic [CW-1:0]            w_old;
    logic [CW:0]              w_sum;
    logic [CW-1:0]            w_sum_clip;
    logic [CW-1:0]            w_nv;
    logic                     w_clip;
    logic [CW+1:0]            w_trial;
    logic [CW+1:0]            w_diff;
    logic                     w_qbit;
    logic [CW-1:0]            w_avg;
    logic [HMS_OUT_W-1:0]     w_out_val;

    // index reduced modulo the character count (power of two)
    assign w_in_idx = HMS_IDX_W'(i_char_index % HMS_NUM_CHARS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SUM;
        end else if (i_cfg_write) begin
            r_mode <= t_stat_mode'(i_cfg_stat_mode);
        end
    end

    // capture the word and read the store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_idx    <= w_in_idx;
            r_cnt    <= CW'(i_occurrence_count);
            r_last   <= i_last_of_array;
            r_rd     <= r_mem[w_in_idx];
            r_rd_vld <= r_vld[w_in_idx];
        end
    end

    assign w_old      = r_rd_vld ? r_rd : '0;
    assign w_sum      = {1'b0, w_old} + {1'b0, r_cnt};
    assign w_clip     = w_sum[CW];
    assign w_sum_clip = w_clip ? {CW{1'b1}} : w_sum[CW-1:0];

    always_comb begin
        w_nv = w_sum_clip;
        case (r_mode)
            MODE_SUM: w_nv = w_sum_clip;
            MODE_MAX: w_nv = (r_cnt > w_old) ? r_cnt : w_old;
            MODE_MIN: begin
                if (w_old == '0 || r_cnt == '0) begin
                    w_nv = (r_cnt > w_old) ? r_cnt : w_old;
                end else begin
                    w_nv = (r_cnt < w_old) ? r_cnt : w_old;
                end
            end
            MODE_AVG: w_nv = w_sum_clip;
            default:  w_nv = w_sum_clip;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_mem[r_idx] <= w_nv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_merged <= '0;
        end else if (i_cmd.update) begin
            r_vld[r_idx] <= 1'b1;
            if (r_mode == MODE_AVG && r_last && r_merged != {HMS_MERGE_W{1'b1}}) begin
                r_merged <= r_merged + 1'b1;
            end
        end
    end

    // restoring divider, one quotient bit a cycle
    assign w_trial = {r_rem, r_quo[CW-1]};
    assign w_diff  = w_trial - (CW+2)'(r_den);
    assign w_qbit  = (w_trial >= (CW+2)'(r_den));

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_nv     <= w_nv;
            r_sat    <= w_clip && (r_mode == MODE_SUM || r_mode == MODE_AVG);
            r_is_avg <= (r_mode == MODE_AVG);
            r_den    <= {1'b0, r_merged} + 1'b1;
            r_quo    <= w_nv;
            r_rem    <= '0;
            r_step   <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= w_qbit ? w_diff[CW:0] : w_trial[CW:0];
            r_quo  <= {r_quo[CW-2:0], w_qbit};
            r_step <= r_step + 1'b1;
        end
    end

    // ceiling: bump the quotient on a nonzero remainder
    assign w_avg     = r_quo + CW'(r_rem != '0);
    assign w_out_val = r_is_avg ? HMS_OUT_W'(w_avg) : HMS_OUT_W'(r_nv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_idx <= HMS_FIELD_IDX_W'(r_idx);
            r_out_val <= w_out_val;
            r_out_sat <= r_sat;
        end
    end

    assign o_status.avg_mode = (r_mode == MODE_AVG);
    assign o_status.div_last = (r_step == {HMS_STEP_W{1'b1}});
    assign o_status.out_busy = r_out_valid && i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_result_index = r_out_idx;
    assign o_stat_value   = r_out_val;
    assign o_saturated    = r_out_sat;

endmodule

>>> rtl/histogram_merge_statistics_top.sv
// ----------------------------------------------------------------------------
// histogram_merge_statistics_top
// merges histogram words into a stored per-character sum, max, min or average
// ----------------------------------------------------------------------------
// Each accepted input word names a character and a count; the block updates
// that character's entry in a 256-entry store and returns one result word
// with the new statistic. Words are processed one at a time: a word passes
// from capture through the update to the output register in sum, max and min
// modes; in average mode a restoring divider after the update makes one
// quotient bit per cycle over the 32 bits of the running total. The output
// register lets the next word be accepted while a result still waits to be
// taken. The store comes out of reset reading all zeros (per-entry valid
// flops), so no clearing pass is needed. stat_mode is written through the
// config port, always ready, and should only change while the block is idle.
module histogram_merge_statistics_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_stat_mode,
    // input words
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [hms_pkg::HMS_FIELD_IDX_W-1:0] i_char_index,
    input  logic [hms_pkg::HMS_OUT_W-1:0]       i_occurrence_count,
    input  logic                                i_last_of_array,
    // result words
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [hms_pkg::HMS_FIELD_IDX_W-1:0] o_result_index,
    output logic [hms_pkg::HMS_OUT_W-1:0]       o_stat_value,
    output logic                                o_saturated
);
    import hms_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_cfg_write;

    // config port is always ready, so every valid write is taken
    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    // sequencer
    hms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // store, arithmetic, divider, output register
    hms_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_cfg_write        (w_cfg_write),
        .i_cfg_stat_mode    (i_cfg_stat_mode),
        .i_char_index       (i_char_index),
        .i_occurrence_count (i_occurrence_count),
        .i_last_of_array    (i_last_of_array),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_result_index     (o_result_index),
        .o_stat_value       (o_stat_value),
        .o_saturated        (o_saturated)
    );

    // one word in flight: after an accept the input side stalls
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a word is in flight");

    // a result is never loaded over one that is still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> !(o_out_valid && i_out_stall))
        else $error("output register overwritten while stalled");

    // a loaded result shows up at the output
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> o_out_valid)
        else $error("loaded result not presented");

endmodule
